[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PTD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PTD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, constants and the colour expansion table of the palette decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int COLOR_W     = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [1:0] MODE_4BPP   = 2'd0;
    localparam logic [1:0] MODE_8BPP   = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_COLOR_MODE = 1'b0;

    typedef struct packed {
        logic                 valid;
        logic                 use_palette;
        logic                 black;
        logic [COLOR_W-1:0]   color;
        logic                 run_last;
        logic                 image_last;
    } ptd_op_t;

    typedef struct packed {
        logic nib_pending;
        logic pair_phase;
    } ptd_status_t;

    // Rounded expansion of a five-bit component to eight bits.
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [7:0] v;
        case (c)
            5'd0:    v = 8'd0;
            5'd1:    v = 8'd8;
            5'd2:    v = 8'd16;
            5'd3:    v = 8'd25;
            5'd4:    v = 8'd33;
            5'd5:    v = 8'd41;
            5'd6:    v = 8'd49;
            5'd7:    v = 8'd58;
            5'd8:    v = 8'd66;
            5'd9:    v = 8'd74;
            5'd10:   v = 8'd82;
            5'd11:   v = 8'd90;
            5'd12:   v = 8'd99;
            5'd13:   v = 8'd107;
            5'd14:   v = 8'd115;
            5'd15:   v = 8'd123;
            5'd16:   v = 8'd132;
            5'd17:   v = 8'd140;
            5'd18:   v = 8'd148;
            5'd19:   v = 8'd156;
            5'd20:   v = 8'd165;
            5'd21:   v = 8'd173;
            5'd22:   v = 8'd181;
            5'd23:   v = 8'd189;
            5'd24:   v = 8'd197;
            5'd25:   v = 8'd206;
            5'd26:   v = 8'd214;
            5'd27:   v = 8'd222;
            5'd28:   v = 8'd230;
            5'd29:   v = 8'd239;
            5'd30:   v = 8'd247;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/ptd_ram.sv]
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/ptd_issue.sv]
// ----------------------------------------------------------------------------
// ptd_issue
// Accepts input transactions, writes the palette, tracks byte pairing and
// issues one pixel operation per cycle with its palette read unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_issue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic [7:0]                    palette_index,
    input  wire logic [ptd_pkg::COLOR_W-1:0]   palette_color,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          last,
    input  wire logic [1:0]                    color_mode,
    input  wire logic                          mode_write,
    input  wire logic                          adv,
    output logic                               ram_wr_en,
    output logic [ptd_pkg::PAL_AW-1:0]         ram_wr_addr,
    output logic [ptd_pkg::COLOR_W-1:0]        ram_wr_data,
    output logic                               ram_rd_en,
    output logic [ptd_pkg::PAL_AW-1:0]         ram_rd_addr,
    output ptd_pkg::ptd_op_t                   op_reg,
    output ptd_pkg::ptd_status_t               status
);

    import ptd_pkg::*;

    logic       accept;
    logic       data_accept;
    logic [7:0] rd_index;
    ptd_op_t    op_next;

    logic       pair_phase_reg;
    logic       pair_phase_next;
    logic [7:0] low_byte_hold_reg;
    logic [7:0] low_byte_hold_next;
    logic       nib_pending_reg;
    logic       nib_pending_next;
    logic [3:0] nib_high_reg;
    logic [3:0] nib_high_next;
    logic       nib_last_reg;
    logic       nib_last_next;

    assign in_stall    = !adv || nib_pending_reg;
    assign accept      = in_valid && !in_stall;
    assign data_accept = accept && (command == CMD_DATA);

    assign ram_wr_en   = accept && (command == CMD_PALETTE)
                         && (9'(palette_index) < 9'(PAL_ENTRIES));
    assign ram_wr_addr = palette_index[PAL_AW-1:0];
    assign ram_wr_data = palette_color;
    assign ram_rd_en   = adv;
    assign ram_rd_addr = rd_index[PAL_AW-1:0];

    assign status.nib_pending = nib_pending_reg;
    assign status.pair_phase  = pair_phase_reg;

    always_comb
    begin
        op_next            = '0;
        rd_index           = 8'd0;
        pair_phase_next    = pair_phase_reg;
        low_byte_hold_next = low_byte_hold_reg;
        nib_pending_next   = nib_pending_reg;
        nib_high_next      = nib_high_reg;
        nib_last_next      = nib_last_reg;

        if (nib_pending_reg && adv)
        begin
            rd_index            = {4'd0, nib_high_reg};
            op_next.valid       = 1'b1;
            op_next.use_palette = 1'b1;
            op_next.run_last    = 1'b1;
            op_next.image_last  = nib_last_reg;
            nib_pending_next    = 1'b0;
        end
        else if (data_accept)
        begin
            case (color_mode)
                MODE_4BPP:
                begin
                    rd_index            = {4'd0, data_byte[3:0]};
                    op_next.valid       = 1'b1;
                    op_next.use_palette = 1'b1;
                    nib_pending_next    = 1'b1;
                    nib_high_next       = data_byte[7:4];
                    nib_last_next       = last;
                end
                MODE_8BPP:
                begin
                    rd_index            = data_byte;
                    op_next.valid       = 1'b1;
                    op_next.use_palette = 1'b1;
                    op_next.run_last    = 1'b1;
                    op_next.image_last  = last;
                end
                default:
                begin
                    if (pair_phase_reg)
                    begin
                        op_next.valid      = 1'b1;
                        op_next.color      = {data_byte, low_byte_hold_reg};
                        op_next.run_last   = 1'b1;
                        op_next.image_last = last;
                        pair_phase_next    = 1'b0;
                    end
                    else
                    begin
                        low_byte_hold_next = data_byte;
                        pair_phase_next    = 1'b1;
                    end
                end
            endcase
            if (last)
            begin
                pair_phase_next = 1'b0;
            end
        end

        op_next.black = op_next.use_palette && (9'(rd_index) >= 9'(PAL_ENTRIES));

        if (mode_write)
        begin
            pair_phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg            <= '0;
            pair_phase_reg    <= 1'b0;
            low_byte_hold_reg <= 8'd0;
            nib_pending_reg   <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                op_reg <= op_next;
            end
            pair_phase_reg    <= pair_phase_next;
            low_byte_hold_reg <= low_byte_hold_next;
            nib_pending_reg   <= nib_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nib_high_reg <= nib_high_next;
        nib_last_reg <= nib_last_next;
    end

endmodule

`default_nettype wire

[rtl/ptd_pixel_out.sv]
// ----------------------------------------------------------------------------
// ptd_pixel_out
// Selects the pixel colour, expands it to RGB888 and holds the result
// transaction in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_pixel_out (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ptd_pkg::ptd_op_t            op,
    input  wire logic [ptd_pkg::COLOR_W-1:0] ram_rd_data,
    output logic                             adv,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             run_last,
    output logic                             image_last
);

    import ptd_pkg::*;

    logic [COLOR_W-1:0] color;
    logic               out_valid_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic               run_last_reg;
    logic               image_last_reg;

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (!op.use_palette)
        begin
            color = op.color;
        end
        else if (op.black)
        begin
            color = '0;
        end
        else
        begin
            color = ram_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= op.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && op.valid)
        begin
            red_reg        <= expand5(color[4:0]);
            green_reg      <= expand5(color[9:5]);
            blue_reg       <= expand5(color[14:10]);
            run_last_reg   <= op.run_last;
            image_last_reg <= op.image_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign run_last   = run_last_reg;
    assign image_last = image_last_reg;

endmodule

`default_nettype wire

[rtl/palette_texture_decoder.sv]
// ----------------------------------------------------------------------------
// palette_texture_decoder
// Converts a texture payload byte stream into RGB888 pixels using a
// 256-entry RGB555 palette or direct sixteen-bit colour.
// ----------------------------------------------------------------------------
// A transaction is either a palette write or one payload byte. In eight-bit
// indexed and direct modes one transaction is taken every cycle unless the
// output stalls; in four-bit mode each byte yields two pixels and holds off
// the next byte until its second pixel issues, as the palette memory has one
// read port and pixels leave through a single output register. A pixel passes
// through the operation register into the output register, the second pixel
// of a four-bit byte after the first; an output stall holds both stages. A
// palette entry written by one transaction may be read by the very next one.
`default_nettype none

`include "assert_macros.svh"

module palette_texture_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ptd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ptd_pkg::APB_DW-1:0]   pwdata,
    output logic      [ptd_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic [7:0]                   palette_index,
    input  wire logic [ptd_pkg::COLOR_W-1:0]  palette_color,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         last,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic                              run_last,
    output logic                              image_last
);

    import ptd_pkg::*;

    logic               pairing_mode;
    logic [1:0]         color_mode_reg;
    logic               mode_write;
    logic               adv;
    logic               ram_wr_en;
    logic [PAL_AW-1:0]  ram_wr_addr;
    logic [COLOR_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [PAL_AW-1:0]  ram_rd_addr;
    logic [COLOR_W-1:0] ram_rd_data;
    ptd_op_t            op_reg;
    ptd_status_t        status;
    logic               nibble_take;
    logic               out_take;

    assign pready     = 1'b1;
    assign mode_write = psel && penable && pwrite && pready
                        && (paddr[2] == REG_COLOR_MODE);
    assign prdata     = (paddr[2] == REG_COLOR_MODE) ? APB_DW'(color_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= MODE_4BPP;
        end
        else if (mode_write)
        begin
            color_mode_reg <= pwdata[1:0];
        end
    end

    // Only direct colour pairs bytes.
    assign pairing_mode = color_mode_reg[1];

    ptd_issue u_issue (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .data_byte     (data_byte),
        .last          (last),
        .color_mode    (color_mode_reg),
        .mode_write    (mode_write),
        .adv           (adv),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .op_reg        (op_reg),
        .status        (status)
    );

    ptd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ptd_pixel_out u_pixel_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op_reg),
        .ram_rd_data (ram_rd_data),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .run_last    (run_last),
        .image_last  (image_last)
    );

    assign nibble_take = in_valid && !in_stall && (command == CMD_DATA)
                         && (color_mode_reg == MODE_4BPP);
    assign out_take    = out_valid && !out_stall;

    `PTD_ASSERT_NXT(a_nibble_held, nibble_take, status.nib_pending)
    `PTD_ASSERT_NXT(a_second_pixel_follows, out_take && !run_last, out_valid && run_last)
    `PTD_ASSERT_IMP(a_pairing_direct_only, status.pair_phase, pairing_mode)

endmodule

`default_nettype wire

[test/palette_pixel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_checker
// Watches the configuration port and both streaming channels of the palette
// decoder, predicts the pixels of each accepted transaction from its own
// copy of the palette, colour mode and pair state, and compares every pixel
// that leaves the decoder with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pixel_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ptd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ptd_pkg::APB_DW-1:0]   pwdata,
    input  wire logic                         pready,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic                         command,
    input  wire logic [7:0]                   palette_index,
    input  wire logic [ptd_pkg::COLOR_W-1:0]  palette_color,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         last,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [7:0]                   red,
    input  wire logic [7:0]                   green,
    input  wire logic [7:0]                   blue,
    input  wire logic                         run_last,
    input  wire logic                         image_last,
    output int                                mismatches,
    output int                                pending,
    output int                                pixels_checked
);

    import ptd_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_last;
        logic       image_last;
    } pixel_t;

    logic [COLOR_W-1:0] palette_copy [PAL_ENTRIES];
    logic [1:0]         mode_reg;
    logic               pair_half;
    logic [7:0]         held_low;
    pixel_t             expected_pixels [$];

    function automatic logic [7:0] widen5(input logic [4:0] c);
        int scaled;
        scaled = (int'(c) * 255 + 15) / 31;
        return scaled[7:0];
    endfunction

    function automatic pixel_t make_pixel(input logic [COLOR_W-1:0] colour,
                                          input logic rl, input logic il);
        pixel_t px;
        px.red        = widen5(colour[4:0]);
        px.green      = widen5(colour[9:5]);
        px.blue       = widen5(colour[14:10]);
        px.run_last   = rl;
        px.image_last = il;
        return px;
    endfunction

    function void add_expected(input pixel_t px);
        expected_pixels.insert(expected_pixels.size(), px);
    endfunction

    function void decode_byte(input logic [7:0] dbyte, input logic lst);
        case (mode_reg)
            MODE_4BPP:
            begin
                add_expected(make_pixel(palette_copy[dbyte[3:0]], 1'b0, 1'b0));
                add_expected(make_pixel(palette_copy[dbyte[7:4]], 1'b1, lst));
            end
            MODE_8BPP:
            begin
                add_expected(make_pixel(palette_copy[dbyte], 1'b1, lst));
            end
            default:
            begin
                if (!pair_half)
                begin
                    held_low  = dbyte;
                    pair_half = 1'b1;
                end
                else
                begin
                    add_expected(make_pixel({dbyte, held_low}, 1'b1, lst));
                    pair_half = 1'b0;
                end
            end
        endcase
        if (lst)
        begin
            pair_half = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            mode_reg       = MODE_4BPP;
            pair_half      = 1'b0;
            held_low       = 8'h00;
            mismatches     = 0;
            pixels_checked = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {red, green, blue, run_last, image_last};
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no pixel, got %0d/%0d/%0d/%0b/%0b",
                             $time, got.red, got.green, got.blue, got.run_last,
                             got.image_last);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: expected %0d/%0d/%0d/%0b/%0b, got %0d/%0d/%0d/%0b/%0b",
                                 $time, want.red, want.green, want.blue, want.run_last,
                                 want.image_last, got.red, got.green, got.blue,
                                 got.run_last, got.image_last);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_COLOR_MODE)
            begin
                mode_reg  = pwdata[1:0];
                pair_half = 1'b0;
            end
            if (in_valid && !in_stall)
            begin
                if (command == CMD_PALETTE)
                begin
                    palette_copy[palette_index] = palette_color;
                end
                else
                begin
                    decode_byte(data_byte, last);
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the palette decoder through a short directed sequence and then
// randomised textures in every colour mode, with random idling on both
// channels, a long output hold-off and drains before each mode change. The
// pixel checker beside the decoder does the prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import ptd_pkg::*;

    localparam logic [1:0] MODE_DIRECT_ALT = 2'd3;
    localparam int         TARGET_ITEMS    = 900;
    localparam int         LONG_HOLD       = 80;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = CMD_PALETTE;
    logic [7:0]          palette_index = 8'h00;
    logic [COLOR_W-1:0]  palette_color = '0;
    logic [7:0]          data_byte = 8'h00;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic                run_last;
    logic                image_last;

    int mismatches;
    int pending;
    int pixels_checked;

    bit written [PAL_ENTRIES];
    int gap_pct = 0;
    int stall_pct = 0;
    bit long_hold_req = 1'b0;
    int items_sent = 0;
    int palette_writes = 0;
    int mode_writes = 0;

    palette_texture_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .data_byte     (data_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .run_last      (run_last),
        .image_last    (image_last)
    );

    palette_pixel_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .palette_index  (palette_index),
        .palette_color  (palette_color),
        .data_byte      (data_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .run_last       (run_last),
        .image_last     (image_last),
        .mismatches     (mismatches),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("palette_texture_decoder: mismatch");
        $finish;
    end

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] idx,
                             input logic [COLOR_W-1:0] col, input logic [7:0] dbyte,
                             input logic lst);
        int gap;
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        palette_index <= idx;
        palette_color <= col;
        data_byte     <= dbyte;
        last          <= lst;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (cmd == CMD_PALETTE)
        begin
            palette_writes++;
            written[idx] = 1'b1;
        end
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [COLOR_W-1:0] col);
        send_item(CMD_PALETTE, idx, col, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_byte(input logic [7:0] dbyte, input logic lst);
        send_item(CMD_DATA, 8'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 65535)),
                  dbyte, lst);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COLOR_MODE, 2'b00};
        pwdata  <= APB_DW'(m);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_writes++;
    endtask

    // Picks a byte whose palette references all point at entries already loaded.
    function automatic logic [7:0] index_byte(input logic [1:0] m);
        logic [3:0] lo;
        logic [3:0] hi;
        logic [7:0] b;
        if (m == MODE_4BPP)
        begin
            do lo = 4'($urandom_range(0, 15)); while (!written[lo]);
            do hi = 4'($urandom_range(0, 15)); while (!written[hi]);
            b = {hi, lo};
        end
        else if (m == MODE_8BPP)
        begin
            do b = 8'($urandom_range(0, 255)); while (!written[b]);
        end
        else
        begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    initial
    begin
        logic [1:0] mode_list [4];
        logic [1:0] mode;
        int         pct_list [4];
        int         p;
        int         k;
        int         r;
        int         len;
        int         tex_left;
        bit         closing;
        logic       lst;

        mode_list = '{MODE_8BPP, MODE_4BPP, MODE_DIRECT, MODE_DIRECT_ALT};
        pct_list  = '{0, 5, 20, 50};

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send_item(CMD_PALETTE, 8'd0, 16'h0000, 8'hFF, 1'b1);
        send_palette(8'd15, 16'hFFFF);
        send_palette(8'd255, 16'h7FFF);
        send_palette(8'd1, 16'h001F);
        send_palette(8'd2, 16'h03E0);
        send_palette(8'd3, 16'h7C00);
        send_byte(8'h00, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h21, 1'b1);
        send_palette(8'd4, 16'h5555);
        send_byte(8'h44, 1'b1);
        set_mode(MODE_8BPP);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h03, 1'b1);
        set_mode(MODE_DIRECT);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h34, 1'b1);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b0);
        set_mode(MODE_DIRECT_ALT);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7C, 1'b1);

        tex_left = $urandom_range(1, 12);
        for (p = 0; items_sent < TARGET_ITEMS; p++)
        begin
            mode    = (p < 4) ? mode_list[p] : mode_list[$urandom_range(0, 3)];
            closing = (items_sent > TARGET_ITEMS - 150);
            gap_pct   = closing ? 0 : pct_list[$urandom_range(0, 3)];
            stall_pct = closing ? 0 : pct_list[$urandom_range(0, 3)];
            set_mode(mode);
            if (p == 0)
            begin
                gap_pct       = 0;
                long_hold_req = 1'b1;
            end
            len = $urandom_range(40, 90);
            for (k = 0; k < len && items_sent < TARGET_ITEMS; k++)
            begin
                if (items_sent > TARGET_ITEMS - 150)
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                r = $urandom_range(1, 100);
                if (mode == MODE_4BPP || mode == MODE_8BPP)
                begin
                    if (r <= 20)
                    begin
                        send_palette(r[0] ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255)),
                                     COLOR_W'($urandom_range(0, 65535)));
                    end
                    else
                    begin
                        lst = (tex_left == 1);
                        tex_left = lst ? $urandom_range(1, 12) : tex_left - 1;
                        send_byte(index_byte(mode), lst);
                    end
                end
                else if (r <= 5)
                begin
                    send_palette(8'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 65535)));
                end
                else if (r <= 10)
                begin
                    send_byte(index_byte(mode), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    lst = (tex_left == 1);
                    tex_left = lst ? $urandom_range(1, 12) : tex_left - 1;
                    send_byte(index_byte(mode), 1'b0);
                    send_byte(index_byte(mode), lst);
                end
            end
        end

        settle();
        repeat (8) @(negedge clk);
        $display("Covered %0d transactions (%0d palette writes, %0d bytes), %0d mode writes.",
                 items_sent, palette_writes, items_sent - palette_writes, mode_writes);
        $display("%0d pixels checked with random idling on both sides and a long hold-off.",
                 pixels_checked);
        if (mismatches == 0 && pending == 0)
        begin
            $display("palette_texture_decoder: match");
        end
        else
        begin
            $display("palette_texture_decoder: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
